### design/rlbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-list bit set engine package
// Shared constants, operation codes, state type and control structs.
// ----------------------------------------------------------------------------
package rlbe_pkg;

    localparam int MAX_RUNS = 256;
    localparam int IDX_W    = $clog2(MAX_RUNS);
    localparam int CNT_W    = $clog2(MAX_RUNS + 1);

    typedef enum logic [2:0] {
        FUNC_TEST   = 3'd0,
        FUNC_SET    = 3'd1,
        FUNC_CLEAR  = 3'd2,
        FUNC_FLIP   = 3'd3,
        FUNC_ONES   = 3'd4,
        FUNC_ZEROS  = 3'd5,
        FUNC_BAD6   = 3'd6,
        FUNC_BAD7   = 3'd7
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TREQ,
        ST_TCHK,
        ST_DECIDE,
        ST_CREQ,
        ST_CCHK,
        ST_CSHL_REQ,
        ST_CSHL_WR,
        ST_SSHR_REQ,
        ST_SSHR_WR,
        ST_SUMREQ,
        ST_SUMACC,
        ST_DONE
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load;       // capture the input item
        logic       clr_ptr;    // pointer to zero
        logic       ptr_top;    // pointer to last entry (run_total - 1)
        logic       inc_ptr;
        logic       dec_ptr;
        logic       rd_ptr;     // read entry at pointer
        logic       rd_next;    // read entry at pointer + 1
        logic       rd_prev;    // read entry at pointer - 1
        logic       hit_set;    // test hit found
        logic       mark_k;     // remember pointer as covering run
        logic       append;     // append run of length one
        logic       trim_lo;
        logic       trim_hi;
        logic       shl_wr;     // write read data to pointer
        logic       shr_wr;     // write read data to pointer + 1
        logic       del_done;   // run_total - 1
        logic       split_wr;   // write upper half at k + 1
        logic       split_lo;   // write lower half at k
        logic       clr_sum;
        logic       acc_sum;
        logic       fail;
        logic       finish;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        t_func      func;
        logic       ptr_end;    // pointer >= run_total
        logic       below_mark; // bit < size mark
        logic       covers;     // read entry covers the bit
        logic       hit;        // test result
        logic       full;
        logic       len_one;
        logic       at_start;
        logic       at_end;
        logic       ptr_at_k;   // pointer equals covering index
        logic       ptr_at_k1;  // pointer equals covering index + 1
        logic       shl_end;    // pointer + 1 >= run_total
        logic       out_busy;
    } t_stat;

endpackage

### design/rlbe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel interface
// Carries one item with its payload between a source and a sink.
// ----------------------------------------------------------------------------
interface rlbe_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/rlbe_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-list bit set datapath
// Run tables, pointer, size mark, ones accumulator and result register.
// ----------------------------------------------------------------------------
module rlbe_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rlbe_pkg::t_cmd      i_cmd,
    output rlbe_pkg::t_stat     o_stat,
    input  logic [2:0]          i_func,
    input  logic [31:0]         i_bit_index,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_bit_value,
    output logic                o_succeeded,
    output logic [31:0]         o_count_value,
    output logic [31:0]         o_bits_in_use,
    output logic [8:0]          o_runs_in_use
);
    import rlbe_pkg::*;

    logic [31:0] r_start_mem [MAX_RUNS];
    logic [31:0] r_len_mem   [MAX_RUNS];
    logic [31:0] r_rd_start, r_rd_len;

    t_func           r_func;
    logic [31:0]     r_bit;
    logic [CNT_W:0]  r_ptr;     // one extra bit so pointer - 1 can go below zero
    logic [IDX_W-1:0] r_k;
    logic [CNT_W-1:0] r_total;
    logic [31:0]     r_mark;
    logic [31:0]     r_sum;
    logic            r_hit;

    logic            r_ov;
    logic            r_bitv, r_ok;
    logic [31:0]     r_cnt;

    // Both halves of a split run, captured when the covering run is found.
    logic [31:0] r_split_start, r_split_len;
    logic [31:0] r_lo_len;

    logic [32:0] w_end;
    logic [CNT_W:0] w_total_x;
    logic [IDX_W-1:0] w_rd_addr, w_wr_addr;
    logic [31:0] w_wr_start, w_wr_len;
    logic        w_we;
    logic [IDX_W-1:0] w_ptr_i;

    assign w_total_x = {1'b0, r_total};
    assign w_ptr_i   = r_ptr[IDX_W-1:0];
    assign w_end     = {1'b0, r_rd_start} + {1'b0, r_rd_len};

    always_comb begin
        w_rd_addr = w_ptr_i;
        if (i_cmd.rd_next) w_rd_addr = IDX_W'(r_ptr + 1'b1);
        if (i_cmd.rd_prev) w_rd_addr = IDX_W'(r_ptr - 1'b1);
        w_we = 1'b0;
        w_wr_addr = w_ptr_i;
        w_wr_start = r_rd_start;
        w_wr_len = r_rd_len;
        if (i_cmd.append) begin
            w_we = 1'b1;
            w_wr_addr = r_total[IDX_W-1:0];
            w_wr_start = r_bit;
            w_wr_len = 32'd1;
        end else if (i_cmd.trim_lo) begin
            w_we = 1'b1;
            w_wr_start = r_rd_start + 32'd1;
            w_wr_len = r_rd_len - 32'd1;
        end else if (i_cmd.trim_hi) begin
            w_we = 1'b1;
            w_wr_len = r_rd_len - 32'd1;
        end else if (i_cmd.shl_wr) begin
            w_we = 1'b1;
        end else if (i_cmd.shr_wr) begin
            w_we = 1'b1;
            w_wr_addr = IDX_W'(r_ptr + 1'b1);
        end else if (i_cmd.split_wr) begin
            w_we = 1'b1;
            w_wr_addr = IDX_W'({1'b0, r_k} + 1'b1);
            w_wr_start = r_bit + 32'd1;
            w_wr_len = r_split_len;
        end else if (i_cmd.split_lo) begin
            w_we = 1'b1;
            w_wr_addr = r_k;
            w_wr_start = r_split_start;
            w_wr_len = r_lo_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_ptr || i_cmd.rd_next || i_cmd.rd_prev) begin
            r_rd_start <= r_start_mem[w_rd_addr];
            r_rd_len   <= r_len_mem[w_rd_addr];
        end
        if (w_we) begin
            r_start_mem[w_wr_addr] <= w_wr_start;
            r_len_mem[w_wr_addr]   <= w_wr_len;
        end
        if (i_cmd.mark_k) begin
            r_k           <= w_ptr_i;
            r_split_start <= r_rd_start;
            r_split_len   <= 32'(w_end - {1'b0, r_bit} - 33'd1);
            r_lo_len      <= r_bit - r_rd_start;
        end
        if (i_cmd.load) begin
            r_func <= t_func'(i_func);
            r_bit  <= i_bit_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_total <= '0;
            r_mark  <= '0;
            r_hit   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.clr_ptr) r_ptr <= '0;
            else if (i_cmd.ptr_top) r_ptr <= w_total_x - 1'b1;
            else if (i_cmd.inc_ptr) r_ptr <= r_ptr + 1'b1;
            else if (i_cmd.dec_ptr) r_ptr <= r_ptr - 1'b1;
            if (i_cmd.load) r_hit <= 1'b0;
            else if (i_cmd.hit_set) r_hit <= 1'b1;
            if (i_cmd.append) begin
                r_total <= r_total + 1'b1;
                if (r_bit == 32'hFFFF_FFFF) r_mark <= 32'hFFFF_FFFF;
                else if (r_bit + 32'd1 > r_mark) r_mark <= r_bit + 32'd1;
            end else if (i_cmd.del_done) r_total <= r_total - 1'b1;
            else if (i_cmd.split_wr) r_total <= r_total + 1'b1;
            if (i_cmd.finish) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_sum) r_sum <= '0;
        else if (i_cmd.acc_sum) r_sum <= r_sum + r_rd_len;
        if (i_cmd.finish) begin
            r_bitv <= (r_func == FUNC_TEST) && r_hit;
            r_ok   <= !i_cmd.fail;
            r_cnt  <= (r_func == FUNC_ONES)  ? r_sum :
                      (r_func == FUNC_ZEROS) ? r_mark - r_sum : 32'd0;
        end
    end

    always_comb begin
        o_stat.func       = r_func;
        o_stat.ptr_end    = r_ptr >= w_total_x;
        o_stat.below_mark = r_bit < r_mark;
        o_stat.covers     = ({1'b0, r_bit} >= {1'b0, r_rd_start}) && ({1'b0, r_bit} < w_end);
        o_stat.hit        = r_hit;
        o_stat.full       = r_total >= CNT_W'(MAX_RUNS);
        o_stat.len_one    = r_rd_len == 32'd1;
        o_stat.at_start   = r_bit == r_rd_start;
        o_stat.at_end     = {1'b0, r_bit} == w_end - 33'd1;
        o_stat.ptr_at_k   = r_ptr == {2'b0, r_k};
        o_stat.ptr_at_k1  = r_ptr == {2'b0, r_k} + 1'b1;
        o_stat.shl_end    = r_ptr + 1'b1 >= w_total_x;
        o_stat.out_busy   = r_ov && !i_out_ready;
    end

    assign o_out_valid   = r_ov;
    assign o_bit_value   = r_bitv;
    assign o_succeeded   = r_ok;
    assign o_count_value = r_cnt;
    assign o_bits_in_use = r_mark;
    assign o_runs_in_use = 9'(r_total);

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(MAX_RUNS))
        else $error("run count beyond table depth");
    a_no_full_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.append && o_stat.full))
        else $error("append into a full table");
    a_total_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.append || i_cmd.split_wr || i_cmd.del_done) |=> $stable(r_total))
        else $error("run count moved without a command");
endmodule

### design/rlbe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-list bit set controller
// Sequences test scans, appends, clear shifts and count sums.
// ----------------------------------------------------------------------------
module rlbe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rlbe_pkg::t_stat i_stat,
    output rlbe_pkg::t_cmd  o_cmd
);
    import rlbe_pkg::*;

    t_state r_state, n_state;
    logic   r_pend, n_pend;          // lower half length still to commit

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pend     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend     <= n_pend;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pend     = 1'b0;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = !i_stat.out_busy;
                if (i_in_valid && !i_stat.out_busy) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.clr_ptr = 1'b1;
                    n_state       = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                unique case (i_stat.func)
                    FUNC_TEST, FUNC_SET, FUNC_FLIP: begin
                        n_state = i_stat.below_mark ? ST_TREQ : ST_DONE;
                        // Tests beyond the mark finish with a miss; set and
                        // flip still need the append path.
                        if (!i_stat.below_mark && i_stat.func != FUNC_TEST)
                            n_state = ST_TCHK;
                    end
                    FUNC_CLEAR: begin
                        n_state    = ST_CREQ;
                    end
                    FUNC_ONES, FUNC_ZEROS: begin
                        o_cmd.clr_sum = 1'b1;
                        n_state       = ST_SUMREQ;
                    end
                    default: begin
                        o_cmd.fail   = 1'b1;
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                endcase
            end
            ST_TREQ: begin
                if (i_stat.ptr_end || i_stat.hit) begin
                    n_state = ST_TCHK;
                end else begin
                    o_cmd.rd_ptr = 1'b1;
                    n_state      = ST_TCHK;
                end
            end
            ST_TCHK: begin
                // Scan step: check the entry just read, or act on the outcome.
                if (!i_stat.ptr_end && !i_stat.hit && i_stat.below_mark) begin
                    if (i_stat.covers) o_cmd.hit_set = 1'b1;
                    o_cmd.inc_ptr = 1'b1;
                    n_state       = ST_TREQ;
                end else if (i_stat.func == FUNC_TEST) begin
                    n_state = ST_DONE;
                end else if (i_stat.hit && i_stat.func == FUNC_FLIP) begin
                    o_cmd.clr_ptr = 1'b1;
                    n_state       = ST_CREQ;
                end else if (i_stat.hit) begin
                    n_state = ST_DONE;
                end else if (i_stat.full) begin
                    o_cmd.fail   = 1'b1;
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_cmd.append = 1'b1;
                    n_state      = ST_DONE;
                end
            end
            ST_CREQ: begin
                if (i_stat.ptr_end) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.rd_ptr = 1'b1;
                    n_state      = ST_CCHK;
                end
            end
            ST_CCHK: begin
                if (!i_stat.covers) begin
                    o_cmd.inc_ptr = 1'b1;
                    n_state       = ST_CREQ;
                end else begin
                    o_cmd.mark_k = 1'b1;
                    if (i_stat.len_one) begin
                        n_state = ST_CSHL_REQ;
                    end else if (i_stat.at_start) begin
                        o_cmd.trim_lo = 1'b1;
                        n_state       = ST_DONE;
                    end else if (i_stat.at_end) begin
                        o_cmd.trim_hi = 1'b1;
                        n_state       = ST_DONE;
                    end else if (i_stat.full) begin
                        o_cmd.fail   = 1'b1;
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        o_cmd.ptr_top = 1'b1;
                        n_state       = ST_SSHR_REQ;
                    end
                end
            end
            ST_CSHL_REQ: begin
                if (i_stat.shl_end) begin
                    o_cmd.del_done = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = ST_CSHL_WR;
                end
            end
            ST_CSHL_WR: begin
                o_cmd.shl_wr  = 1'b1;
                o_cmd.inc_ptr = 1'b1;
                n_state       = ST_CSHL_REQ;
            end
            ST_SSHR_REQ: begin
                // Pointer walks down from the last entry to k, shifting entries k+1 and above up by one.
                if (i_stat.ptr_at_k) begin
                    o_cmd.split_wr = 1'b1;
                    n_pend         = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.rd_ptr = 1'b1;
                    n_state      = ST_SSHR_WR;
                end
            end
            ST_SSHR_WR: begin
                o_cmd.shr_wr  = 1'b1;
                o_cmd.dec_ptr = 1'b1;
                n_state       = ST_SSHR_REQ;
            end
            ST_SUMREQ: begin
                if (i_stat.ptr_end) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.rd_ptr = 1'b1;
                    n_state      = ST_SUMACC;
                end
            end
            ST_SUMACC: begin
                o_cmd.acc_sum = 1'b1;
                o_cmd.inc_ptr = 1'b1;
                n_state       = ST_SUMREQ;
            end
            ST_DONE: begin
                // After a split, the lower half goes into the table in the cycle
                // after the upper half.
                if (r_pend) begin
                    o_cmd.split_lo = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_DECIDE)
        else $error("load did not start an operation");
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == ST_IDLE)
        else $error("finish did not return to idle");
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !o_in_ready)
        else $error("ready raised mid operation");
endmodule

### design/run_list_bitset_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-list bit set engine
// One item at a time; the next item is taken once the result has left or
// leaves in the same cycle. The single-port run table read sets the pace.
// Reset clears run count and size mark; no clearing pass.
// ----------------------------------------------------------------------------
module run_list_bitset_engine_unit (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rlbe_if.sink   in_ch,
    rlbe_if.source out_ch
);
    import rlbe_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    rlbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rlbe_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_func        (in_ch.data[34:32]),
        .i_bit_index   (in_ch.data[31:0]),
        .i_out_ready   (out_ch.ready),
        .o_out_valid   (out_ch.valid),
        .o_bit_value   (out_ch.data[74]),
        .o_succeeded   (out_ch.data[73]),
        .o_count_value (out_ch.data[72:41]),
        .o_bits_in_use (out_ch.data[40:9]),
        .o_runs_in_use (out_ch.data[8:0])
    );
endmodule

### tb/rlbe_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result layout for the run-list bit set engine bench
// Packed layout of one result item as it travels on the output channel.
// ----------------------------------------------------------------------------
package rlbe_tb_pkg;

    typedef struct packed {
        logic        bit_value;
        logic        succeeded;
        logic [31:0] count_value;
        logic [31:0] bits_in_use;
        logic [8:0]  runs_in_use;
    } t_bitset_reply;

endpackage

### tb/tb_run_list_bitset_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-list bit set engine testbench
// Drives test, set, clear, flip, count and unused-code items through the
// valid/ready channels, predicts each reply from a private copy of the run
// table and compares every field of every reply in order.
// ----------------------------------------------------------------------------
module tb_run_list_bitset_engine_unit;
    import rlbe_pkg::*;
    import rlbe_tb_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int STALL_LIMIT = 40000;

    class run_list_ledger;
        logic [31:0]   seg_start [MAX_RUNS];
        logic [31:0]   run_len   [MAX_RUNS];
        int unsigned   run_count;
        logic [31:0]   size_mark;
        t_bitset_reply pending [$];

        function new();
            run_count = 0;
            size_mark = 0;
        endfunction

        function bit covered(int unsigned k, logic [31:0] b);
            logic [32:0] s;
            logic [32:0] e;
            s = {1'b0, seg_start[k]};
            e = s + {1'b0, run_len[k]};
            return ({1'b0, b} >= s) && ({1'b0, b} < e);
        endfunction

        function bit probe(logic [31:0] b);
            if (b >= size_mark) return 0;
            for (int unsigned k = 0; k < run_count; k++)
                if (covered(k, b)) return 1;
            return 0;
        endfunction

        function bit mark_one(logic [31:0] b);
            if (probe(b)) return 1;
            if (run_count >= MAX_RUNS) return 0;
            seg_start[run_count] = b;
            run_len[run_count]   = 32'd1;
            run_count++;
            if (b == 32'hFFFF_FFFF) size_mark = 32'hFFFF_FFFF;
            else if (b + 32'd1 > size_mark) size_mark = b + 32'd1;
            return 1;
        endfunction

        function bit erase_one(logic [31:0] b);
            logic [31:0] s;
            logic [31:0] len;
            for (int unsigned k = 0; k < run_count; k++) begin
                if (!covered(k, b)) continue;
                s   = seg_start[k];
                len = run_len[k];
                if (len == 32'd1) begin
                    for (int unsigned j = k; j + 1 < run_count; j++) begin
                        seg_start[j] = seg_start[j+1];
                        run_len[j]   = run_len[j+1];
                    end
                    run_count--;
                end else if (b == s) begin
                    seg_start[k] = s + 32'd1;
                    run_len[k]   = len - 32'd1;
                end else if ({1'b0, b} == {1'b0, s} + {1'b0, len} - 33'd1) begin
                    run_len[k] = len - 32'd1;
                end else begin
                    if (run_count >= MAX_RUNS) return 0;
                    for (int unsigned j = run_count; j > k + 1; j--) begin
                        seg_start[j] = seg_start[j-1];
                        run_len[j]   = run_len[j-1];
                    end
                    run_len[k]     = b - s;
                    seg_start[k+1] = b + 32'd1;
                    run_len[k+1]   = s + len - b - 32'd1;
                    run_count++;
                end
                return 1;
            end
            return 1;
        endfunction

        function logic [31:0] ones_sum();
            logic [31:0] t;
            t = 0;
            for (int unsigned k = 0; k < run_count; k++) t += run_len[k];
            return t;
        endfunction

        function void note_item(t_func f, logic [31:0] b);
            t_bitset_reply r;
            r = '0;
            r.succeeded = 1'b1;
            case (f)
                FUNC_TEST:  r.bit_value = probe(b);
                FUNC_SET:   r.succeeded = mark_one(b);
                FUNC_CLEAR: r.succeeded = erase_one(b);
                FUNC_FLIP:  r.succeeded = probe(b) ? erase_one(b) : mark_one(b);
                FUNC_ONES:  r.count_value = ones_sum();
                FUNC_ZEROS: r.count_value = size_mark - ones_sum();
                default:    r.succeeded = 1'b0;
            endcase
            r.bits_in_use = size_mark;
            r.runs_in_use = run_count[8:0];
            pending.push_back(r);
        endfunction

        // Returns an empty string when the reply matches the oldest expectation.
        function string check_reply(t_bitset_reply got);
            t_bitset_reply want;
            if (pending.size() == 0) return "reply with no item outstanding";
            want = pending.pop_front();
            if (got.bit_value !== want.bit_value)
                return $sformatf("bit_value %0b, expected %0b", got.bit_value, want.bit_value);
            if (got.succeeded !== want.succeeded)
                return $sformatf("succeeded %0b, expected %0b", got.succeeded, want.succeeded);
            if (got.count_value !== want.count_value)
                return $sformatf("count_value %h, expected %h",
                                 got.count_value, want.count_value);
            if (got.bits_in_use !== want.bits_in_use)
                return $sformatf("bits_in_use %h, expected %h",
                                 got.bits_in_use, want.bits_in_use);
            if (got.runs_in_use !== want.runs_in_use)
                return $sformatf("runs_in_use %0d, expected %0d",
                                 got.runs_in_use, want.runs_in_use);
            return "";
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rlbe_if #(.W(35)) in_if ();
    rlbe_if #(.W(75)) out_if ();

    run_list_bitset_engine_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_if.sink),
        .out_ch  (out_if.source)
    );

    run_list_ledger ledger;
    int  mismatches;
    int  idle_cycles;
    int  hold_cycles;
    bit  calm;

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    task automatic report(string msg);
        mismatches++;
        $display("[%0t] reply error: %s", $time, msg);
    endtask

    // Reply monitor and ready driver share one process.
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            msg = ledger.check_reply(t_bitset_reply'(out_if.data));
            if (msg != "") report(msg);
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
        end
    end

    // Watchdog on cycles with no accepted item on either side.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send(t_func f, logic [31:0] b);
        if (!calm && $urandom_range(99) < 34) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= {f, b};
        do @(posedge i_clk); while (!in_if.ready);
        ledger.note_item(f, b);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (ledger.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_index();
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom_range(63);
        endcase
    endfunction

    function automatic t_func pick_func();
        int r;
        r = $urandom_range(99);
        if (r < 20) return FUNC_TEST;
        if (r < 45) return FUNC_SET;
        if (r < 65) return FUNC_CLEAR;
        if (r < 85) return FUNC_FLIP;
        if (r < 91) return FUNC_ONES;
        if (r < 97) return FUNC_ZEROS;
        return (r < 99) ? FUNC_BAD6 : FUNC_BAD7;
    endfunction

    initial begin
        ledger       = new();
        mismatches   = 0;
        idle_cycles  = 0;
        hold_cycles  = 0;
        calm         = 0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners: empty table, top bit, unused codes, uncovered clear.
        send(FUNC_ONES, 32'd0);
        send(FUNC_ZEROS, 32'hFFFF_FFFF);
        send(FUNC_TEST, 32'd0);
        send(FUNC_CLEAR, 32'd5);
        send(FUNC_SET, 32'd0);
        send(FUNC_SET, 32'd0);
        send(FUNC_TEST, 32'd0);
        send(FUNC_SET, 32'hFFFF_FFFF);
        send(FUNC_TEST, 32'hFFFF_FFFF);
        send(FUNC_SET, 32'hFFFF_FFFF);
        send(FUNC_FLIP, 32'hFFFF_FFFE);
        send(FUNC_FLIP, 32'hFFFF_FFFE);
        send(FUNC_ZEROS, 32'd0);
        send(FUNC_ONES, 32'd0);
        send(FUNC_CLEAR, 32'hFFFF_FFFF);
        send(FUNC_CLEAR, 32'd0);
        send(FUNC_BAD6, 32'h5555_5555);
        send(FUNC_BAD7, 32'hAAAA_AAAA);
        send(FUNC_FLIP, 32'd7);
        send(FUNC_TEST, 32'd7);
        drain();

        // Long receiver hold-off while items keep coming.
        hold_cycles = 300;
        for (int i = 0; i < 8; i++) send(pick_func(), pick_index());

        // Quiet stretch with no idling on either side.
        calm = 1;
        for (int i = 0; i < 150; i++) send(pick_func(), pick_index());
        calm = 0;
        drain();

        // Fill the table to the limit, then hit the full-table cases.
        for (int i = 0; i < MAX_RUNS + 4; i++) send(FUNC_SET, 32'd1000 + 3 * i);
        send(FUNC_SET, 32'd5);
        send(FUNC_FLIP, 32'd6);
        send(FUNC_SET, 32'hFFFF_FFFF);
        send(FUNC_ONES, 32'd0);
        send(FUNC_ZEROS, 32'd0);
        for (int i = 0; i < 240; i++) send(FUNC_CLEAR, 32'd1000 + 3 * $urandom_range(259));
        drain();

        for (int i = 0; i < 500; i++) send(pick_func(), pick_index());
        drain();

        repeat (2 * MAX_RUNS * 2 + 20) @(posedge i_clk);
        if (mismatches == 0 && ledger.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

### filelist.f
design/rlbe_pkg.sv
design/rlbe_if.sv
design/rlbe_datapath.sv
design/rlbe_ctrl.sv
design/run_list_bitset_engine_unit.sv
tb/rlbe_tb_if.sv
tb/tb_run_list_bitset_engine_unit.sv
